[src/sct_pkg.sv]
`default_nettype none
package sct_pkg;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  exam;
        logic [4:0]  slot;
        logic [23:0] conflict_total;
    } sct_req_t;

    typedef struct packed {
        logic [7:0] chosen_exam;
        logic       chosen_valid;
        logic [4:0] prior_slot;
        logic [1:0] error_code;
    } sct_rsp_t;

    localparam logic [2:0] KIND_CLEAR  = 3'd0;
    localparam logic [2:0] KIND_LOAD   = 3'd1;
    localparam logic [2:0] KIND_PLACE  = 3'd2;
    localparam logic [2:0] KIND_UNPL   = 3'd3;
    localparam logic [2:0] KIND_ADD    = 3'd4;
    localparam logic [2:0] KIND_DROP   = 3'd5;
    localparam logic [2:0] KIND_SELECT = 3'd6;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_UNPLACED = 2'd1;
    localparam logic [1:0] ERR_UNDER    = 2'd2;
    localparam logic [1:0] ERR_RANGE    = 2'd3;

    localparam logic CFG_EXAMS = 1'b0;
    localparam logic CFG_SLOTS = 1'b1;

    localparam int unsigned COUNT_W = 9;
    localparam int unsigned WEIGHT_W = 24;

endpackage
`default_nettype wire

[src/sct_ram.sv]
`default_nettype none
module sct_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[src/saturation_coloring_tracker.sv]
`default_nettype none
// Channel | Direction | Handshake        | Payload
// req     | in        | req_valid/ready  | sct_req_t
// rsp     | out       | rsp_valid/ready  | sct_rsp_t
// cfg     | in        | cfg_we           | cfg_index, cfg_data
// Update requests step through read, modify/write and respond; select_next scans
// every exam in use through the single read port of the exam memory.
// After reset, and after a clear request, a clearing pass sweeps the memories (all
// MAX_EXAMS*MAX_SLOTS count entries and the exam records); no request is taken meanwhile.
// A stalled response holds in its output register; the next request waits for it.
module saturation_coloring_tracker #(
    parameter int unsigned MAX_EXAMS = 256,
    parameter int unsigned MAX_SLOTS = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire sct_pkg::sct_req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output sct_pkg::sct_rsp_t      rsp,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [8:0]        cfg_data
);
    import sct_pkg::*;

    localparam int unsigned EW = $clog2(MAX_EXAMS);
    localparam int unsigned SW = $clog2(MAX_SLOTS);
    localparam int unsigned NW = EW + SW;
    localparam int unsigned NDEPTH = MAX_EXAMS * MAX_SLOTS;
    // Exam record: placed, slot, map, tally, weight.
    localparam int unsigned TW = SW + 1;
    localparam int unsigned RW = 1 + SW + MAX_SLOTS + TW + WEIGHT_W;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_MOD  = 3'd3;
    localparam logic [2:0] ST_SCAN = 3'd4;
    localparam logic [2:0] ST_RSP  = 3'd5;

    typedef struct packed {
        logic                placed;
        logic [SW-1:0]       slot;
        logic [MAX_SLOTS-1:0] fmap;
        logic [TW-1:0]       tally;
        logic [WEIGHT_W-1:0] weight;
    } rec_t;

    logic [2:0]          state_reg, state_next;
    logic [8:0]          exams_reg;
    logic [5:0]          slots_reg;
    sct_req_t            cur_reg;
    sct_rsp_t            rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [NW:0]         clr_reg, clr_next;
    logic                clr_rsp_reg, clr_rsp_next;
    logic [EW:0]         scan_reg, scan_next;
    logic                scan_live_reg, scan_live_next;
    logic [EW-1:0]       scan_idx_reg, scan_idx_next;
    logic                best_v_reg, best_v_next;
    logic [TW-1:0]       best_t_reg, best_t_next;
    logic [WEIGHT_W-1:0] best_w_reg, best_w_next;
    logic [EW-1:0]       best_i_reg, best_i_next;

    logic                rec_we, cnt_we;
    logic [EW-1:0]       rec_waddr, rec_raddr;
    rec_t                rec_wdata, rec_rdata;
    logic [NW-1:0]       cnt_waddr, cnt_raddr;
    logic [COUNT_W-1:0]  cnt_wdata, cnt_rdata;

    logic [EW:0]         live_exams;
    logic [SW:0]         live_slots;
    logic                exam_ok, slot_ok;
    logic [NW-1:0]       cur_idx;

    sct_ram #(.WIDTH(RW), .DEPTH(MAX_EXAMS)) u_rec (
        .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
        .raddr(rec_raddr), .rdata(rec_rdata)
    );
    sct_ram #(.WIDTH(COUNT_W), .DEPTH(NDEPTH)) u_cnt (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(cnt_raddr), .rdata(cnt_rdata)
    );

    // Register limits, clamped to what the stores hold.
    always_comb
    begin
        if ({23'd0, exams_reg} > 32'(MAX_EXAMS))
        begin
            live_exams = (EW+1)'(MAX_EXAMS);
        end
        else
        begin
            live_exams = (EW+1)'(exams_reg);
        end
        if ({26'd0, slots_reg} > 32'(MAX_SLOTS))
        begin
            live_slots = (SW+1)'(MAX_SLOTS);
        end
        else
        begin
            live_slots = (SW+1)'(slots_reg);
        end
    end

    assign exam_ok = {24'd0, cur_reg.exam} < {{(32-EW-1){1'b0}}, live_exams};
    assign slot_ok = {27'd0, cur_reg.slot} < {{(32-SW-1){1'b0}}, live_slots};
    assign cur_idx = {EW'(cur_reg.exam), SW'(cur_reg.slot)};

    assign req_ready = (state_reg == ST_IDLE) && !rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

    // Main sequencer: clearing pass; read, modify and write back; scan for select_next; respond.
    always_comb
    begin
        rec_t r;
        logic [COUNT_W-1:0] c;
        logic [SW-1:0] s;
        r = rec_rdata;
        c = cnt_rdata;
        s = SW'(cur_reg.slot);
        state_next = state_reg;
        rsp_next = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        clr_next = clr_reg;
        clr_rsp_next = clr_rsp_reg;
        scan_next = scan_reg;
        scan_live_next = 1'b0;
        scan_idx_next = scan_idx_reg;
        best_v_next = best_v_reg;
        best_t_next = best_t_reg;
        best_w_next = best_w_reg;
        best_i_next = best_i_reg;
        rec_we = 1'b0;
        rec_waddr = EW'(cur_reg.exam);
        rec_wdata = r;
        rec_raddr = EW'(cur_reg.exam);
        cnt_we = 1'b0;
        cnt_waddr = cur_idx;
        cnt_wdata = c;
        cnt_raddr = cur_idx;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLR:
            begin
                cnt_we = 1'b1;
                cnt_waddr = clr_reg[NW-1:0];
                cnt_wdata = '0;
                rec_we = (clr_reg[NW-1:0] < NW'(MAX_EXAMS));
                rec_waddr = EW'(clr_reg[NW-1:0]);
                rec_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (NW+1)'(NDEPTH - 1))
                begin
                    // Only a clear request answers; the pass after reset does not.
                    state_next = clr_rsp_reg ? ST_RSP : ST_IDLE;
                    clr_rsp_next = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    rec_raddr = EW'(req.exam);
                    cnt_raddr = {EW'(req.exam), SW'(req.slot)};
                    rsp_next = '0;
                    unique case (req.kind)
                        KIND_CLEAR:
                        begin
                            clr_next = '0;
                            clr_rsp_next = 1'b1;
                            state_next = ST_CLR;
                        end
                        KIND_SELECT:
                        begin
                            scan_next = '0;
                            best_v_next = 1'b0;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_RD;
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                state_next = ST_RSP;
                rec_we = 1'b1;
                case (cur_reg.kind)
                    KIND_LOAD:
                    begin
                        if (!exam_ok)
                        begin
                            rsp_next.error_code = ERR_RANGE;
                            rec_we = 1'b0;
                        end
                        else
                        begin
                            rec_wdata.weight = cur_reg.conflict_total;
                        end
                    end
                    KIND_PLACE:
                    begin
                        if (!exam_ok || !slot_ok)
                        begin
                            rsp_next.error_code = ERR_RANGE;
                            rec_we = 1'b0;
                        end
                        else
                        begin
                            rec_wdata.placed = 1'b1;
                            rec_wdata.slot = s;
                        end
                    end
                    KIND_UNPL:
                    begin
                        rec_we = 1'b0;
                        if (!exam_ok)
                        begin
                            rsp_next.error_code = ERR_RANGE;
                        end
                        else if (!r.placed)
                        begin
                            rsp_next.error_code = ERR_UNPLACED;
                        end
                        else
                        begin
                            rsp_next.prior_slot = 5'(r.slot);
                            rec_wdata.placed = 1'b0;
                            rec_we = 1'b1;
                        end
                    end
                    KIND_ADD:
                    begin
                        if (!exam_ok || !slot_ok)
                        begin
                            rsp_next.error_code = ERR_RANGE;
                            rec_we = 1'b0;
                        end
                        else
                        begin
                            if (c == '0)
                            begin
                                rec_wdata.fmap[s] = 1'b1;
                                rec_wdata.tally = r.tally + 1'b1;
                            end
                            else
                            begin
                                rec_we = 1'b0;
                            end
                            if (c != '1)
                            begin
                                cnt_we = 1'b1;
                                cnt_wdata = c + 1'b1;
                            end
                        end
                    end
                    KIND_DROP:
                    begin
                        rec_we = 1'b0;
                        if (!exam_ok || !slot_ok)
                        begin
                            rsp_next.error_code = ERR_RANGE;
                        end
                        else if (c == '0)
                        begin
                            rsp_next.error_code = ERR_UNDER;
                        end
                        else
                        begin
                            cnt_we = 1'b1;
                            cnt_wdata = c - 1'b1;
                            if (c == COUNT_W'(1))
                            begin
                                rec_we = 1'b1;
                                rec_wdata.fmap[s] = 1'b0;
                                rec_wdata.tally = r.tally - 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        rec_we = 1'b0;
                    end
                endcase
            end
            ST_SCAN:
            begin
                // Issue one read per cycle; compare the entry read last cycle.
                rec_raddr = EW'(scan_reg);
                if (scan_reg < live_exams)
                begin
                    scan_next = scan_reg + 1'b1;
                    scan_live_next = 1'b1;
                    scan_idx_next = EW'(scan_reg);
                end
                if (scan_live_reg && !r.placed)
                begin
                    if (!best_v_reg || r.tally > best_t_reg
                        || (r.tally == best_t_reg && r.weight > best_w_reg))
                    begin
                        best_v_next = 1'b1;
                        best_t_next = r.tally;
                        best_w_next = r.weight;
                        best_i_next = scan_idx_reg;
                    end
                end
                if (!(scan_reg < live_exams) && !scan_live_reg)
                begin
                    rsp_next.chosen_valid = best_v_reg;
                    rsp_next.chosen_exam = best_v_reg ? 8'(best_i_reg) : 8'd0;
                    state_next = ST_RSP;
                end
            end
            ST_RSP:
            begin
                rsp_valid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            clr_reg <= '0;
            clr_rsp_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            exams_reg <= 9'd256;
            slots_reg <= 6'd32;
            scan_live_reg <= 1'b0;
            cur_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            clr_rsp_reg <= clr_rsp_next;
            rsp_valid_reg <= rsp_valid_next;
            scan_live_reg <= scan_live_next;
            if (req_valid && req_ready)
            begin
                cur_reg <= req;
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_EXAMS)
                begin
                    exams_reg <= cfg_data;
                end
                else
                begin
                    slots_reg <= cfg_data[5:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        scan_reg <= scan_next;
        scan_idx_reg <= scan_idx_next;
        best_v_reg <= best_v_next;
        best_t_reg <= best_t_next;
        best_w_reg <= best_w_next;
        best_i_reg <= best_i_next;
    end
endmodule
`default_nettype wire
